// File: hdl/cwsp_pkg.sv
// cwsp_pkg: shared types, constants and helpers for the command line word splitter
// used by every module of the splitter; depends on nothing else

package cwsp_pkg;

   // request and result payloads
   typedef struct packed {
      logic       cmd;
      logic [7:0] in_byte;
   } req_type;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] out_byte;
      logic [7:0] arg_count;
      logic       last_of_run;
   } rsp_type;

   // one queued run: the results that one request causes, in emission order
   typedef struct packed {
      logic       emit_byte;
      logic [7:0] data_byte;
      logic       emit_arg_end;
      logic       emit_cmd_end;
      logic [7:0] count;
   } run_type;

   // request command codes
   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   // result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_ARG_END = 2'd1;
   localparam logic [1:0] KIND_CMD_END = 2'd2;

   // special characters
   localparam logic [7:0] CHAR_BACKSLASH = 8'h5c;
   localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
   localparam logic [7:0] CHAR_SPACE     = 8'h20;
   localparam logic [7:0] CHAR_TAB       = 8'h09;
   localparam logic [7:0] CHAR_CR        = 8'h0d;

   // run queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

   // register port
   localparam int          CSR_ADDR_W     = 3;
   localparam int          CSR_DATA_W     = 32;
   localparam logic        CSR_IDX_LIMIT  = 1'b0;
   localparam logic [7:0]  ARG_LIMIT_INIT = 8'd127;

   // whitespace: tab through carriage return, and space
   function automatic logic is_white(input logic [7:0] b);
      is_white = (b == CHAR_SPACE) || ((b >= CHAR_TAB) && (b <= CHAR_CR));
   endfunction

endpackage

// File: hdl/cwsp_front.sv
// cwsp_front: accepts requests, tracks quote/escape/argument state, builds result runs
// depends on cwsp_pkg

module cwsp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  cwsp_pkg::req_type req_data,
   input  logic [7:0]        arg_limit,
   input  logic              q_full,
   output logic              q_push,
   output cwsp_pkg::run_type q_data
);

   // phase codes
   localparam logic [1:0] PH_BETWEEN = 2'd0;
   localparam logic [1:0] PH_IN_ARG  = 2'd1;
   localparam logic [1:0] PH_IGNORE  = 2'd2;

   // open quote codes
   localparam logic [1:0] Q_NONE   = 2'd0;
   localparam logic [1:0] Q_SINGLE = 2'd1;
   localparam logic [1:0] Q_DOUBLE = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [1:0] quote_ff, quote_in;
   logic       esc_ff, esc_in;
   logic [7:0] args_ff, args_in;

   logic              accept;
   logic              white;
   logic              process;
   logic [1:0]        eff_quote;
   logic              eff_esc;
   logic [1:0]        byte_quote;
   cwsp_pkg::run_type run;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign white     = cwsp_pkg::is_white(req_data.in_byte);

   // next state and run for the request at the port
   always_comb begin
      phase_in  = phase_ff;
      quote_in  = quote_ff;
      esc_in    = esc_ff;
      args_in   = args_ff;
      process   = 1'b0;
      eff_quote = quote_ff;
      eff_esc   = esc_ff;

      run.emit_byte    = 1'b0;
      run.data_byte    = req_data.in_byte;
      run.emit_arg_end = 1'b0;
      run.emit_cmd_end = 1'b0;
      run.count        = args_ff;

      byte_quote = (req_data.in_byte == cwsp_pkg::CHAR_SQUOTE) ? Q_SINGLE : Q_DOUBLE;

      if (req_data.cmd == cwsp_pkg::CMD_END) begin
         // end of string: flush a pending backslash, close the argument, report
         if (phase_ff == PH_IN_ARG) begin
            run.emit_byte    = esc_ff;
            run.data_byte    = cwsp_pkg::CHAR_BACKSLASH;
            run.emit_arg_end = 1'b1;
         end
         run.emit_cmd_end = 1'b1;
         phase_in = PH_BETWEEN;
         quote_in = Q_NONE;
         esc_in   = 1'b0;
         args_in  = '0;
      end else begin
         // argument start or limit check
         unique case (phase_ff)
            PH_BETWEEN: begin
               if (!white) begin
                  if (args_ff >= arg_limit) begin
                     phase_in = PH_IGNORE;
                  end else begin
                     phase_in  = PH_IN_ARG;
                     eff_quote = Q_NONE;
                     eff_esc   = 1'b0;
                     process   = 1'b1;
                  end
               end
            end
            PH_IN_ARG: process = 1'b1;
            default:   process = 1'b0;
         endcase

         // byte handling inside an argument
         if (process) begin
            quote_in = eff_quote;
            esc_in   = eff_esc;
            if (eff_esc) begin
               esc_in        = 1'b0;
               run.emit_byte = 1'b1;
            end else if (req_data.in_byte == cwsp_pkg::CHAR_BACKSLASH) begin
               esc_in = 1'b1;
            end else if ((req_data.in_byte == cwsp_pkg::CHAR_SQUOTE) ||
                         (req_data.in_byte == cwsp_pkg::CHAR_DQUOTE)) begin
               if (eff_quote == Q_NONE) begin
                  quote_in = byte_quote;
               end else if (eff_quote == byte_quote) begin
                  quote_in = Q_NONE;
               end else begin
                  run.emit_byte = 1'b1;
               end
            end else if (white && (eff_quote == Q_NONE)) begin
               args_in          = args_ff + 8'd1;
               phase_in         = PH_BETWEEN;
               run.emit_arg_end = 1'b1;
            end else begin
               run.emit_byte = 1'b1;
            end
         end
      end
   end

   assign q_push = accept && (run.emit_byte || run.emit_arg_end || run.emit_cmd_end);
   assign q_data = run;

   // string state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_BETWEEN;
         quote_ff <= Q_NONE;
         esc_ff   <= 1'b0;
         args_ff  <= '0;
      end else if (accept) begin
         phase_ff <= phase_in;
         quote_ff <= quote_in;
         esc_ff   <= esc_in;
         args_ff  <= args_in;
      end
   end

endmodule

// File: hdl/cwsp_queue.sv
// cwsp_queue: small first-in first-out queue of result runs between front and back
// depends on cwsp_pkg

module cwsp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  cwsp_pkg::run_type push_data,
   input  logic              pop,
   output cwsp_pkg::run_type pop_data,
   output logic              not_empty,
   output logic              full
);

   cwsp_pkg::run_type entry_ff [cwsp_pkg::QUEUE_DEPTH];

   logic [cwsp_pkg::QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [cwsp_pkg::QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [cwsp_pkg::QUEUE_CW-1:0] count_ff, count_in;

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == cwsp_pkg::QUEUE_CW'(cwsp_pkg::QUEUE_DEPTH));
   assign pop_data  = entry_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// File: hdl/cwsp_back.sv
// cwsp_back: takes runs from the queue and hands out their results one per cycle unless the receiver stalls
// depends on cwsp_pkg

module cwsp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  cwsp_pkg::run_type q_data,
   output logic              q_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output cwsp_pkg::rsp_type rsp_data
);

   cwsp_pkg::run_type cur_ff, cur_in;
   logic              cur_valid_ff, cur_valid_in;

   cwsp_pkg::run_type rest;
   logic              fire;
   logic              done;

   assign rsp_valid = cur_valid_ff;

   // leading result of the current run and what remains after it
   always_comb begin
      rest = cur_ff;
      rsp_data.out_byte = '0;
      if (cur_ff.emit_byte) begin
         rsp_data.kind        = cwsp_pkg::KIND_BYTE;
         rsp_data.out_byte    = cur_ff.data_byte;
         rsp_data.arg_count   = cur_ff.count;
         rsp_data.last_of_run = !(cur_ff.emit_arg_end || cur_ff.emit_cmd_end);
         rest.emit_byte       = 1'b0;
      end else if (cur_ff.emit_arg_end) begin
         rsp_data.kind        = cwsp_pkg::KIND_ARG_END;
         rsp_data.arg_count   = cur_ff.count + 8'd1;
         rsp_data.last_of_run = !cur_ff.emit_cmd_end;
         rest.emit_arg_end    = 1'b0;
         rest.count           = cur_ff.count + 8'd1;
      end else begin
         rsp_data.kind        = cwsp_pkg::KIND_CMD_END;
         rsp_data.arg_count   = cur_ff.count;
         rsp_data.last_of_run = 1'b1;
         rest.emit_cmd_end    = 1'b0;
      end
   end

   // advance within a run, load the next run as the current one finishes
   assign fire  = cur_valid_ff && !rsp_stall;
   assign done  = fire && rsp_data.last_of_run;
   assign q_pop = q_valid && (!cur_valid_ff || done);

   always_comb begin
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      if (q_pop) begin
         cur_valid_in = 1'b1;
         cur_in       = q_data;
      end else if (done) begin
         cur_valid_in = 1'b0;
      end else if (fire) begin
         cur_in = rest;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

endmodule

// File: hdl/command_line_word_splitter_unit.sv
// command_line_word_splitter_unit: top level of the command line word splitter
// depends on cwsp_pkg, cwsp_front, cwsp_queue, cwsp_back

// Splits a command string, one byte per request, into arguments. A request
// with cmd 0 carries a string byte, cmd 1 ends the string. Results are
// argument bytes, argument ends and a command end carrying the final count;
// last_of_run marks the final result of each request. The front accepts one
// request per cycle while the run queue is not full and turns it into a run
// of zero to three results, which waits in a four-entry run queue; the back
// hands out one result per cycle unless the receiver stalls. A string end
// inside an argument gives three results with a pending backslash and two
// without; every other request gives at most one. arg_limit (register 0,
// byte address 0) is to be written through the register port only while
// the block is idle, which it does not enforce; it is read back on the same port.

module command_line_word_splitter_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  cwsp_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output cwsp_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [cwsp_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [cwsp_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [cwsp_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   logic [7:0] arg_limit_ff;

   logic              q_push;
   cwsp_pkg::run_type q_push_data;
   logic              q_pop;
   cwsp_pkg::run_type q_pop_data;
   logic              q_not_empty;
   logic              q_full;
   logic              csr_hit;

   // register port
   assign csr_pready = 1'b1;
   assign csr_hit    = (csr_paddr[2] == cwsp_pkg::CSR_IDX_LIMIT);
   assign csr_prdata = csr_hit ? {{(cwsp_pkg::CSR_DATA_W-8){1'b0}}, arg_limit_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         arg_limit_ff <= cwsp_pkg::ARG_LIMIT_INIT;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         arg_limit_ff <= csr_pwdata[7:0];
      end
   end

   // request parsing
   cwsp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .arg_limit (arg_limit_ff),
      .q_full    (q_full),
      .q_push    (q_push),
      .q_data    (q_push_data)
   );

   // run queue
   cwsp_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .not_empty (q_not_empty),
      .full      (q_full)
   );

   // result emission
   cwsp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_not_empty),
      .q_data    (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: bench/tb_top.sv
// tb_top: self-checking bench for command_line_word_splitter_unit
// depends on cwsp_pkg and the splitter RTL; a scoreboard class predicts every result

module tb_top;

   localparam int RUN_LIMIT     = 100000;
   localparam int DRAIN_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 300;
   localparam int PHASE_ITEMS   = 44;
   localparam int MAX_TEXT_LEN  = 12;
   localparam logic [cwsp_pkg::CSR_ADDR_W-1:0] LIMIT_ADDR =
      cwsp_pkg::CSR_ADDR_W'(4 * cwsp_pkg::CSR_IDX_LIMIT);

   typedef enum logic [1:0] {SPLIT_BETWEEN, SPLIT_IN_ARG, SPLIT_IGNORE} split_phase_type;
   typedef enum logic [1:0] {QUOTE_NONE, QUOTE_SINGLE, QUOTE_DOUBLE} quote_type;

   // predicts the argument pieces of each request and checks them in order
   class splitter_scoreboard;
      logic [7:0]        arg_limit;
      split_phase_type   phase;
      quote_type         quote;
      bit                escape_pending;
      logic [7:0]        args_done;
      cwsp_pkg::rsp_type run[$];
      cwsp_pkg::rsp_type expected_pieces[$];
      int                error_count;
      int                checked;

      function new();
         arg_limit = cwsp_pkg::ARG_LIMIT_INIT;
         clear_string();
         error_count = 0;
         checked = 0;
      endfunction

      function void clear_string();
         phase = SPLIT_BETWEEN;
         quote = QUOTE_NONE;
         escape_pending = 1'b0;
         args_done = 8'd0;
      endfunction

      static function bit is_space(logic [7:0] b);
         return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
      endfunction

      function void add_piece(logic [1:0] piece_kind, logic [7:0] b);
         run.push_back(cwsp_pkg::rsp_type'{kind: piece_kind, out_byte: b,
                                          arg_count: args_done, last_of_run: 1'b0});
      endfunction

      function string show(cwsp_pkg::rsp_type x);
         return $sformatf("kind=%0d byte=%02h count=%0d last=%0b",
                          x.kind, x.out_byte, x.arg_count, x.last_of_run);
      endfunction

      task report(string msg);
         error_count++;
         if (error_count <= 40) begin
            $display("mismatch: %s", msg);
         end
      endtask

      // accepted request: step the splitter state and queue its pieces
      function void note_request(cwsp_pkg::req_type r);
         bit        go;
         quote_type q;
         go = 1'b1;
         run.delete();
         if (r.cmd == cwsp_pkg::CMD_END) begin
            if (phase == SPLIT_IN_ARG) begin
               if (escape_pending) add_piece(cwsp_pkg::KIND_BYTE, cwsp_pkg::CHAR_BACKSLASH);
               args_done++;
               add_piece(cwsp_pkg::KIND_ARG_END, 8'h00);
            end
            add_piece(cwsp_pkg::KIND_CMD_END, 8'h00);
            clear_string();
         end else if (phase != SPLIT_IGNORE) begin
            // a new argument may start only below the limit
            if (phase == SPLIT_BETWEEN) begin
               if (is_space(r.in_byte)) begin
                  go = 1'b0;
               end else if (args_done >= arg_limit) begin
                  phase = SPLIT_IGNORE;
                  go = 1'b0;
               end else begin
                  phase = SPLIT_IN_ARG;
                  quote = QUOTE_NONE;
                  escape_pending = 1'b0;
               end
            end
            if (go) begin
               if (escape_pending) begin
                  escape_pending = 1'b0;
                  add_piece(cwsp_pkg::KIND_BYTE, r.in_byte);
               end else if (r.in_byte == cwsp_pkg::CHAR_BACKSLASH) begin
                  escape_pending = 1'b1;
               end else if (r.in_byte == cwsp_pkg::CHAR_SQUOTE ||
                            r.in_byte == cwsp_pkg::CHAR_DQUOTE) begin
                  q = (r.in_byte == cwsp_pkg::CHAR_SQUOTE) ? QUOTE_SINGLE : QUOTE_DOUBLE;
                  if (quote == QUOTE_NONE) quote = q;
                  else if (quote == q) quote = QUOTE_NONE;
                  else add_piece(cwsp_pkg::KIND_BYTE, r.in_byte);
               end else if (is_space(r.in_byte) && quote == QUOTE_NONE) begin
                  args_done++;
                  phase = SPLIT_BETWEEN;
                  add_piece(cwsp_pkg::KIND_ARG_END, 8'h00);
               end else begin
                  add_piece(cwsp_pkg::KIND_BYTE, r.in_byte);
               end
            end
         end
         if (run.size() != 0) run[run.size() - 1].last_of_run = 1'b1;
         foreach (run[i]) expected_pieces.push_back(run[i]);
      endfunction

      // accepted result: compare with the oldest expected piece
      task check_result(cwsp_pkg::rsp_type got);
         cwsp_pkg::rsp_type want;
         if (expected_pieces.size() == 0) begin
            report($sformatf("result %0d with nothing expected: %s", checked, show(got)));
         end else begin
            want = expected_pieces.pop_front();
            if (got !== want) begin
               report($sformatf("result %0d: got %s, expected %s",
                                checked, show(got), show(want)));
            end
         end
         checked++;
      endtask
   endclass

   logic                            clock;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   cwsp_pkg::req_type               req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   cwsp_pkg::rsp_type               rsp_data;
   logic                            csr_psel;
   logic                            csr_penable;
   logic                            csr_pwrite;
   logic [cwsp_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [cwsp_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [cwsp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   splitter_scoreboard sb = new();
   int sent_items = 0;
   int cycle_count = 0;
   bit req_no_gaps = 1'b0;
   bit rsp_no_gaps = 1'b0;
   bit rsp_long_hold = 1'b0;

   command_line_word_splitter_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   // both handshakes observed in one place, request first
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) sb.note_request(req_data);
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // result side: random stall before each result, one long hold on request
   initial begin
      int gap;
      rsp_stall <= 1'b1;
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_long_hold) begin
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_long_hold = 1'b0;
         end
         gap = rsp_no_gaps ? 0 : $urandom_range(0, 3);
         if (gap != 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // one request, after a random gap, held until accepted
   task automatic send_req(input logic is_end, input logic [7:0] value);
      int gap;
      gap = req_no_gaps ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{cmd: is_end, in_byte: value};
      do @(posedge clock); while (req_stall);
      sent_items++;
   endtask

   task automatic send_text(input string s);
      foreach (s[i]) send_req(cwsp_pkg::CMD_BYTE, s[i]);
   endtask

   // wait until every expected piece has come, then let the pipe settle
   task automatic wait_drained();
      int waited;
      req_valid <= 1'b0;
      waited = 0;
      while (sb.expected_pieces.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.expected_pieces.size() != 0) begin
         sb.report($sformatf("%0d results never arrived", sb.expected_pieces.size()));
         sb.expected_pieces.delete();
      end
   endtask

   task automatic read_limit();
      logic [7:0] seen;
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= LIMIT_ADDR;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      seen = csr_prdata[7:0];
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (seen !== sb.arg_limit) begin
         sb.report($sformatf("arg_limit read %0d, expected %0d", seen, sb.arg_limit));
      end
   endtask

   // write then read back; upper data bits are don't-care for the register
   task automatic write_limit(input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= LIMIT_ADDR;
      csr_pwdata <= {24'($urandom), value};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.arg_limit = value;
      read_limit();
   endtask

   // mix of letters, whitespace, quotes, backslashes and arbitrary bytes
   function automatic logic [7:0] random_char();
      int roll;
      int w;
      roll = $urandom_range(0, 99);
      w = $urandom_range(0, 5);
      if (roll < 45) return 8'($urandom_range(97, 122));
      if (roll < 60) return (w == 5) ? cwsp_pkg::CHAR_SPACE : 8'(9 + w);
      if (roll < 68) return cwsp_pkg::CHAR_SQUOTE;
      if (roll < 76) return cwsp_pkg::CHAR_DQUOTE;
      if (roll < 84) return cwsp_pkg::CHAR_BACKSLASH;
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic send_random_strings(input int count);
      int len;
      int start;
      start = sent_items;
      while (sent_items - start < count) begin
         len = $urandom_range(0, MAX_TEXT_LEN);
         repeat (len) send_req(cwsp_pkg::CMD_BYTE, random_char());
         send_req(cwsp_pkg::CMD_END, 8'($urandom));
      end
   endtask

   initial begin
      logic [7:0] limits [6];
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      read_limit();

      // byte extremes, zero byte as data, ignored byte on string end
      send_req(cwsp_pkg::CMD_BYTE, 8'h00);
      send_req(cwsp_pkg::CMD_BYTE, 8'hff);
      send_req(cwsp_pkg::CMD_END, 8'hff);
      // empty quotes, other quote literal inside a span, backslash at end
      send_text("'' \"'\"x\\");
      send_req(cwsp_pkg::CMD_END, 8'h00);
      // escaped space, tab inside a quote, quote left open at end
      send_text("\\ 'a\tb");
      send_req(cwsp_pkg::CMD_END, 8'h00);
      // limit lowered mid string: the next argument is ignored
      send_text("a b ");
      wait_drained();
      write_limit(8'd1);
      send_text("c");
      send_req(cwsp_pkg::CMD_END, 8'h00);

      // random strings under several limits, extremes included
      limits = '{8'd255, 8'd2, 8'd1, 8'd3, 8'($urandom_range(4, 254)), 8'd127};
      foreach (limits[i]) begin
         wait_drained();
         write_limit(limits[i]);
         req_no_gaps = ($urandom_range(0, 3) == 0);
         rsp_no_gaps = ($urandom_range(0, 3) == 0);
         if (i == 3) begin
            // receiver holds off while requests keep coming
            req_no_gaps = 1'b1;
            rsp_long_hold = 1'b1;
         end
         send_random_strings(PHASE_ITEMS);
      end

      wait_drained();
      if (sb.error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
